// ----- rtl/core/iqdf_pkg.sv -----
package iqdf_pkg;

  localparam int TAPS = 32;
  localparam int SAMPLE_W = 16;
  localparam int OUT_W = 14;
  localparam int PEAK_W = 37;
  localparam int SUM_W = 48;
  localparam int PROD_W = 32;
  localparam int NORM_SCALE = 8191;
  localparam int NORM_SHIFT = 13;
  localparam int NORM_W = 62;
  localparam logic [PEAK_W-1:0] PEAK_LIMIT = PEAK_W'(64'd1 << 36);
  localparam int DEC_W = 7;
  localparam logic [DEC_W-1:0] DEC_RESET = 7'd4;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_PEAK,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

endpackage

// ----- rtl/core/iqdf_if.sv -----
interface iqdf_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [15:0] i_sample;
  logic signed [15:0] q_sample;
  logic [4:0] tap_index;
  logic signed [15:0] coefficient;
  modport source (output valid, cmd, i_sample, q_sample, tap_index, coefficient, input ready);
  modport sink (input valid, cmd, i_sample, q_sample, tap_index, coefficient, output ready);
endinterface

interface iqdf_out_if;
  logic valid;
  logic ready;
  logic signed [13:0] out_i;
  logic signed [13:0] out_q;
  logic [36:0] peak;
  logic peak_sign;
  modport source (output valid, out_i, out_q, peak, peak_sign, input ready);
  modport sink (input valid, out_i, out_q, peak, peak_sign, output ready);
endinterface

// ----- rtl/core/iqdf_lane.sv -----
module iqdf_lane (
  input  logic clk,
  input  logic acc_clear,
  input  logic acc_en,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] coef,
  output logic signed [iqdf_pkg::SUM_W-1:0] acc
);
  logic signed [iqdf_pkg::PROD_W-1:0] prod_r;
  logic prod_v_r;
  logic signed [iqdf_pkg::SUM_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= sample * coef;
    prod_v_r <= acc_en;
    if (acc_clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + iqdf_pkg::SUM_W'(prod_r);
    end
  end

  assign acc = acc_r;
endmodule

// ----- rtl/core/iqdf_div.sv -----
// Restoring divider: |num| / den, one quotient bit a cycle.
module iqdf_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [iqdf_pkg::NORM_W-1:0] num,
  input  logic [iqdf_pkg::PEAK_W-1:0] den,
  output logic done,
  output logic [iqdf_pkg::NORM_W-1:0] quot
);
  localparam int CW = $clog2(iqdf_pkg::NORM_W + 1);
  logic [iqdf_pkg::NORM_W-1:0] q_r, q_nxt;
  logic [iqdf_pkg::PEAK_W:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [iqdf_pkg::PEAK_W:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[iqdf_pkg::PEAK_W-1:0], q_r[iqdf_pkg::NORM_W-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(iqdf_pkg::NORM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt = {q_r[iqdf_pkg::NORM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[iqdf_pkg::NORM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ----- rtl/core/iq_decimating_fir_peak_normalizer_unit.sv -----
// Channel | Dir | Payload
// in_     | in  | cmd, i_sample, q_sample, tap_index, coefficient
// out_    | out | out_i, out_q, peak, peak_sign
// cfg_    | in  | decimation_factor (7 bits)
// Coefficient items and samples that produce no result leave the block idle.
// A sample that produces a result holds the input off through the MAC walk
// (one tap a cycle in each lane), the peak state, two passes of the shared
// divider and the output state, longer while the previous result still waits
// in the output register. rst_n is synchronous; the delay line is covered by
// the fill count, not cleared per entry.
module iq_decimating_fir_peak_normalizer_unit (
  input  logic clk,
  input  logic rst_n,
  iqdf_in_if.sink in_ch,
  iqdf_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [6:0] cfg_wdata
);
  localparam int AW = $clog2(iqdf_pkg::TAPS);
  localparam int FW = $clog2(iqdf_pkg::TAPS + 1);

  iqdf_pkg::state_t st_r, st_nxt;
  logic [iqdf_pkg::DEC_W-1:0] dec_r;
  logic signed [15:0] coef_mem [iqdf_pkg::TAPS];
  logic signed [15:0] i_mem [iqdf_pkg::TAPS];
  logic signed [15:0] q_mem [iqdf_pkg::TAPS];
  logic [AW-1:0] head_r;      // slot of oldest sample
  logic [FW-1:0] fill_r;
  logic [iqdf_pkg::DEC_W-1:0] phase_r;
  logic [FW:0] mcnt_r;
  logic [AW-1:0] rd_tap;
  logic signed [15:0] rd_i_r, rd_q_r, rd_c_r;
  logic rd_v_r;
  logic [iqdf_pkg::PEAK_W-1:0] peak_r;
  logic peak_seen_r, peak_neg_r;
  logic div_sel_r;
  logic signed [iqdf_pkg::SUM_W-1:0] acc_i, acc_q;
  logic signed [iqdf_pkg::SUM_W-1:0] si_r, sq_r;
  logic signed [iqdf_pkg::OUT_W-1:0] res_i_r, res_q_r;
  logic signed [iqdf_pkg::OUT_W-1:0] oi_r, oq_r;
  logic [iqdf_pkg::PEAK_W-1:0] opeak_r;
  logic osign_r;
  logic out_v_r;
  logic out_load;
  iqdf_pkg::mac_ctl_t mac;
  logic div_start, div_done;
  logic [iqdf_pkg::NORM_W-1:0] div_num, div_q;
  logic acc_i_ok;
  logic [iqdf_pkg::DEC_W-1:0] dec_eff;
  logic in_acc, fire;
  logic [iqdf_pkg::SUM_W-1:0] abs_i, abs_q;
  logic signed [iqdf_pkg::SUM_W-1:0] sel_sum;
  logic signed [iqdf_pkg::SUM_W-1:0] num_sum;
  logic [iqdf_pkg::SUM_W-1:0] num_abs;
  logic [iqdf_pkg::NORM_W-1:0] mag_scaled;
  logic [iqdf_pkg::OUT_W-1:0] qsat;
  logic signed [iqdf_pkg::OUT_W-1:0] qres;

  function automatic logic [iqdf_pkg::PEAK_W-1:0] sat_abs(
      input logic [iqdf_pkg::SUM_W-1:0] a);
    sat_abs = (a > iqdf_pkg::SUM_W'(iqdf_pkg::PEAK_LIMIT)) ? iqdf_pkg::PEAK_LIMIT
              : a[iqdf_pkg::PEAK_W-1:0];
  endfunction

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == iqdf_pkg::ST_IDLE);
  assign dec_eff = (dec_r == '0) ? iqdf_pkg::DEC_W'(1) : dec_r;
  assign fire = in_acc && (in_ch.cmd == iqdf_pkg::CMD_SAMPLE) &&
                ((fill_r == FW'(iqdf_pkg::TAPS - 1)) ||
                 (fill_r == FW'(iqdf_pkg::TAPS) && (phase_r + 1'b1) >= dec_eff));
  // hand the result over once the output register is free
  assign out_load = (st_r == iqdf_pkg::ST_OUT) && (!out_v_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      iqdf_pkg::ST_IDLE: if (fire) st_nxt = iqdf_pkg::ST_MAC;
      iqdf_pkg::ST_MAC: if (mcnt_r == (FW+1)'(iqdf_pkg::TAPS + 3)) st_nxt = iqdf_pkg::ST_PEAK;
      iqdf_pkg::ST_PEAK: st_nxt = iqdf_pkg::ST_DIV;
      iqdf_pkg::ST_DIV: if (div_done && div_sel_r) st_nxt = iqdf_pkg::ST_OUT;
      iqdf_pkg::ST_OUT: if (out_load) st_nxt = iqdf_pkg::ST_IDLE;
      default: st_nxt = iqdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mac.clear = (st_r == iqdf_pkg::ST_IDLE);
    mac.start = rd_v_r;
    div_start = (st_r == iqdf_pkg::ST_PEAK) ||
                (st_r == iqdf_pkg::ST_DIV && div_done && !div_sel_r);
  end

  assign rd_tap = AW'(mcnt_r);
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == iqdf_pkg::CMD_COEF &&
        {3'b0, in_ch.tap_index} < 8'(iqdf_pkg::TAPS))
      coef_mem[AW'(in_ch.tap_index)] <= in_ch.coefficient;
    if (in_acc && in_ch.cmd == iqdf_pkg::CMD_SAMPLE) begin
      i_mem[head_r] <= in_ch.i_sample;
      q_mem[head_r] <= in_ch.q_sample;
    end
    rd_i_r <= i_mem[AW'(head_r + rd_tap)];
    rd_q_r <= q_mem[AW'(head_r + rd_tap)];
    rd_c_r <= coef_mem[rd_tap];
  end

  iqdf_lane u_lane_i (.clk(clk), .acc_clear(mac.clear), .acc_en(mac.start),
    .sample(rd_i_r), .coef(rd_c_r), .acc(acc_i));
  iqdf_lane u_lane_q (.clk(clk), .acc_clear(mac.clear), .acc_en(mac.start),
    .sample(rd_q_r), .coef(rd_c_r), .acc(acc_q));

  assign abs_i = acc_i[iqdf_pkg::SUM_W-1] ? -acc_i : acc_i;
  assign abs_q = acc_q[iqdf_pkg::SUM_W-1] ? -acc_q : acc_q;
  assign acc_i_ok = abs_i >= abs_q;
  assign sel_sum = div_sel_r ? sq_r : si_r;
  // I is divided first, straight from the lane; Q follows from its register
  assign num_sum = (st_r == iqdf_pkg::ST_PEAK) ? acc_i : sq_r;
  assign num_abs = num_sum[iqdf_pkg::SUM_W-1] ? -num_sum : num_sum;
  assign mag_scaled = (iqdf_pkg::NORM_W'(num_abs) << iqdf_pkg::NORM_SHIFT)
                      - iqdf_pkg::NORM_W'(num_abs);
  assign div_num = mag_scaled;
  assign qsat = (div_q > iqdf_pkg::NORM_W'(iqdf_pkg::NORM_SCALE) || peak_r == '0) ?
                ((peak_r == '0) ? '0 : iqdf_pkg::OUT_W'(iqdf_pkg::NORM_SCALE))
                : div_q[iqdf_pkg::OUT_W-1:0];
  assign qres = sel_sum[iqdf_pkg::SUM_W-1] ? -$signed(qsat) : $signed(qsat);

  iqdf_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den((peak_r == '0) ? iqdf_pkg::PEAK_W'(1) : peak_r), .done(div_done), .quot(div_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= iqdf_pkg::ST_IDLE;
      dec_r <= iqdf_pkg::DEC_RESET;
      head_r <= '0;
      fill_r <= '0;
      phase_r <= '0;
      mcnt_r <= '0;
      rd_v_r <= 1'b0;
      peak_r <= '0;
      peak_seen_r <= 1'b0;
      peak_neg_r <= 1'b0;
      div_sel_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) dec_r <= cfg_wdata;
      if (in_acc && in_ch.cmd == iqdf_pkg::CMD_SAMPLE) begin
        head_r <= (head_r == AW'(iqdf_pkg::TAPS - 1)) ? '0 : head_r + 1'b1;
        if (fill_r != FW'(iqdf_pkg::TAPS)) fill_r <= fill_r + 1'b1;
        phase_r <= (fire || fill_r != FW'(iqdf_pkg::TAPS)) ? '0 : phase_r + 1'b1;
      end
      // walk taps oldest first; samples read after head advanced
      rd_v_r <= (st_r == iqdf_pkg::ST_MAC) && (mcnt_r < (FW+1)'(iqdf_pkg::TAPS));
      mcnt_r <= (st_r == iqdf_pkg::ST_MAC) ? mcnt_r + 1'b1 : '0;
      if (st_r == iqdf_pkg::ST_PEAK) begin
        si_r <= acc_i;
        sq_r <= acc_q;
        div_sel_r <= 1'b0;
        peak_seen_r <= 1'b1;
        if (!peak_seen_r) begin
          peak_r <= sat_abs(acc_i_ok ? abs_i : abs_q);
          peak_neg_r <= acc_i_ok ? acc_i[iqdf_pkg::SUM_W-1] : acc_q[iqdf_pkg::SUM_W-1];
        end else if (abs_q > iqdf_pkg::SUM_W'(peak_r) && abs_q > abs_i) begin
          peak_r <= sat_abs(abs_q);
          peak_neg_r <= acc_q[iqdf_pkg::SUM_W-1];
        end else if (abs_i > iqdf_pkg::SUM_W'(peak_r)) begin
          if (abs_q > sat_abs(abs_i) && abs_q > iqdf_pkg::SUM_W'(peak_r)) begin
            peak_r <= sat_abs(abs_q);
            peak_neg_r <= acc_q[iqdf_pkg::SUM_W-1];
          end else begin
            peak_r <= sat_abs(abs_i);
            peak_neg_r <= acc_i[iqdf_pkg::SUM_W-1];
          end
        end else if (abs_q > iqdf_pkg::SUM_W'(peak_r)) begin
          peak_r <= sat_abs(abs_q);
          peak_neg_r <= acc_q[iqdf_pkg::SUM_W-1];
        end
      end
      if (st_r == iqdf_pkg::ST_DIV && div_done) begin
        if (!div_sel_r) res_i_r <= qres;
        else res_q_r <= qres;
        div_sel_r <= 1'b1;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
        oi_r <= res_i_r;
        oq_r <= res_q_r;
        opeak_r <= peak_r;
        osign_r <= peak_neg_r;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.out_i = oi_r;
  assign out_ch.out_q = oq_r;
  assign out_ch.peak = opeak_r;
  assign out_ch.peak_sign = osign_r;

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != iqdf_pkg::ST_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_peak_lim: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= iqdf_pkg::PEAK_LIMIT) else $error("peak over limit");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(st_r == iqdf_pkg::ST_OUT)) else $error("stray result");
`endif
endmodule

// ----- bench/iqdf_checker.sv -----
`timescale 1ns / 1ps

module iqdf_checker (
  input  logic clk,
  input  logic rst_n,
  iqdf_in_if in_ch,
  iqdf_out_if out_ch,
  input  logic cfg_we,
  input  logic [6:0] cfg_wdata,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic signed [iqdf_pkg::OUT_W-1:0] out_i;
    logic signed [iqdf_pkg::OUT_W-1:0] out_q;
    logic [iqdf_pkg::PEAK_W-1:0] peak;
    logic peak_sign;
  } norm_result_t;

  logic signed [iqdf_pkg::SAMPLE_W-1:0] i_line [iqdf_pkg::TAPS];
  logic signed [iqdf_pkg::SAMPLE_W-1:0] q_line [iqdf_pkg::TAPS];
  logic signed [iqdf_pkg::SAMPLE_W-1:0] taps [iqdf_pkg::TAPS];
  longint peak_mag;
  bit have_peak;
  bit peak_neg;
  int filled;
  int phase;
  logic [iqdf_pkg::DEC_W-1:0] decim;
  norm_result_t expected_q [$];

  function automatic logic signed [iqdf_pkg::OUT_W-1:0] scale_to_peak(longint sum);
    longint r;
    r = 0;
    if (peak_mag != 0) begin
      r = (sum * iqdf_pkg::NORM_SCALE) / peak_mag;
      if (r > iqdf_pkg::NORM_SCALE) r = iqdf_pkg::NORM_SCALE;
      if (r < -iqdf_pkg::NORM_SCALE) r = -iqdf_pkg::NORM_SCALE;
    end
    return r[iqdf_pkg::OUT_W-1:0];
  endfunction

  function automatic void set_peak(longint sum);
    longint a;
    a = sum < 0 ? -sum : sum;
    peak_mag = a > longint'(iqdf_pkg::PEAK_LIMIT) ? longint'(iqdf_pkg::PEAK_LIMIT) : a;
    peak_neg = sum < 0;
  endfunction

  function automatic void filter_and_queue();
    longint si, sq, ai, aq;
    norm_result_t r;
    si = 0;
    sq = 0;
    for (int k = 0; k < iqdf_pkg::TAPS; k++) begin
      si += longint'(i_line[k]) * longint'(taps[k]);
      sq += longint'(q_line[k]) * longint'(taps[k]);
    end
    ai = si < 0 ? -si : si;
    aq = sq < 0 ? -sq : sq;
    if (!have_peak) begin
      set_peak(ai >= aq ? si : sq);
      have_peak = 1;
    end else begin
      if (ai > peak_mag) set_peak(si);
      if (aq > peak_mag) set_peak(sq);
    end
    r.out_i = scale_to_peak(si);
    r.out_q = scale_to_peak(sq);
    r.peak = peak_mag[iqdf_pkg::PEAK_W-1:0];
    r.peak_sign = peak_neg;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void absorb_item(logic cmd, logic signed [15:0] iv,
                                      logic signed [15:0] qv, logic [4:0] idx,
                                      logic signed [15:0] cv);
    int dec;
    if (cmd == iqdf_pkg::CMD_COEF) begin
      if (idx < iqdf_pkg::TAPS) taps[idx] = cv;
      return;
    end
    for (int k = 1; k < iqdf_pkg::TAPS; k++) begin
      i_line[k-1] = i_line[k];
      q_line[k-1] = q_line[k];
    end
    i_line[iqdf_pkg::TAPS-1] = iv;
    q_line[iqdf_pkg::TAPS-1] = qv;
    if (filled < iqdf_pkg::TAPS) begin
      filled++;
      if (filled == iqdf_pkg::TAPS) begin
        phase = 0;
        filter_and_queue();
      end
      return;
    end
    dec = decim == 0 ? 1 : int'(decim);
    phase++;
    if (phase >= dec) begin
      phase = 0;
      filter_and_queue();
    end
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    norm_result_t e;
    if (!rst_n) begin
      for (int k = 0; k < iqdf_pkg::TAPS; k++) begin
        i_line[k] = '0;
        q_line[k] = '0;
        taps[k] = '0;
      end
      peak_mag = 0;
      have_peak = 0;
      peak_neg = 0;
      filled = 0;
      phase = 0;
      decim = iqdf_pkg::DEC_RESET;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) decim = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation: out_i %0d out_q %0d peak %0d",
                 out_ch.out_i, out_ch.out_q, out_ch.peak);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.out_i !== e.out_i) begin
            $error("out_i expected %0d actual %0d", e.out_i, out_ch.out_i);
            fail_count++;
          end
          if (out_ch.out_q !== e.out_q) begin
            $error("out_q expected %0d actual %0d", e.out_q, out_ch.out_q);
            fail_count++;
          end
          if (out_ch.peak !== e.peak) begin
            $error("peak expected %0d actual %0d", e.peak, out_ch.peak);
            fail_count++;
          end
          if (out_ch.peak_sign !== e.peak_sign) begin
            $error("peak_sign expected %0d actual %0d", e.peak_sign, out_ch.peak_sign);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        absorb_item(in_ch.cmd, in_ch.i_sample, in_ch.q_sample, in_ch.tap_index,
                    in_ch.coefficient);
    end
  end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  localparam int SETTLE = 400;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int sent;

  iqdf_in_if in_ch ();
  iqdf_out_if out_ch ();

  iq_decimating_fir_peak_normalizer_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  iqdf_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: count cycles where neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic signed [15:0] iv, logic signed [15:0] qv,
                           logic [4:0] idx, logic signed [15:0] cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.i_sample <= iv;
    in_ch.q_sample <= qv;
    in_ch.tap_index <= idx;
    in_ch.coefficient <= cv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_pair(logic signed [15:0] iv, logic signed [15:0] qv);
    send_item(iqdf_pkg::CMD_SAMPLE, iv, qv, 5'($urandom), 16'($urandom));
  endtask

  task automatic send_tap(logic [4:0] idx, logic signed [15:0] cv);
    send_item(iqdf_pkg::CMD_COEF, 16'($urandom), 16'($urandom), idx, cv);
  endtask

  // Hold until the block has drained, then write the register.
  task automatic set_decimation(logic [6:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    unique case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_idling(int mode);
    unique case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  initial begin
    logic [6:0] decim_plan [10] = '{7'd1, 7'd0, 7'd64, 7'd2, 7'd127, 7'd3, 7'd1, 7'd7,
                                   7'd5, 7'd4};
    int per_phase;
    sent = 0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= iqdf_pkg::CMD_SAMPLE;
    in_ch.i_sample <= '0;
    in_ch.q_sample <= '0;
    in_ch.tap_index <= '0;
    in_ch.coefficient <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole tap table before any sample, with extreme taps mixed in.
    for (int k = 0; k < 32; k++)
      send_tap(5'(k), k == 0 ? 16'sh8000 : k == 31 ? 16'sh7fff : k == 5 ? 16'sh0000
                      : pick_value());
    // Zero window gives a zero peak on the first output.
    for (int k = 0; k < 32; k++) send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh7fff, 16'sh7fff);
    // Equal I and Q drive a tie between the two sums.
    for (int k = 0; k < 8; k++) send_pair(16'sh8000, 16'sh8000);

    // Raise the factor, count pairs, then lower it below the pairs already counted.
    set_decimation(7'd64);
    for (int k = 0; k < 10; k++) send_pair(pick_value(), pick_value());
    set_decimation(7'd1);
    send_pair(16'sh1234, -16'sh1234);

    for (int p = 0; p < 10; p++) begin
      set_idling(p);
      set_decimation(decim_plan[p]);
      per_phase = decim_plan[p] >= 64 ? 136 : 68;
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(99) < 8)
          send_tap(5'($urandom), pick_value());
        else
          send_pair(pick_value(), pick_value());
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
